>>> rtl/mktg_pkg.sv
// ----------------------------------------------------------------------------
// mktg_pkg - morse keyer tone generator package
// command codes, register indexes, field widths, control states and the
// character to dot/dash pattern table
// ----------------------------------------------------------------------------
package mktg_pkg;

   // field widths
   localparam int CMD_W    = 3;
   localparam int CHAR_W   = 8;
   localparam int SAMPLE_W = 9;
   localparam int DOT_W    = 15;
   localparam int TONE_W   = 10;
   localparam int LEVEL_W  = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 15;

   localparam int PATTERN_BITS_DEFAULT = 1024;

   // longest character pattern, and the width of a pattern length
   localparam int MORSE_W     = 22;
   localparam int MORSE_LEN_W = 5;
   localparam int ROM_BITS_W  = 32;

   // command codes
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_APPEND = 3'd1;
   localparam logic [CMD_W-1:0] CMD_START  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_STOP   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_TICK   = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_DOT_SAMPLES = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TONE_PERIOD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_HIGH_LEVEL  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_LOW_LEVEL   = 2'd3;

   // register reset values
   localparam logic [DOT_W-1:0]   DOT_SAMPLES_RST = 15'd1200;
   localparam logic [TONE_W-1:0]  TONE_PERIOD_RST = 10'd24;
   localparam logic [LEVEL_W-1:0] LEVEL_RST       = 8'd0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SHIFT,
      ST_TICK,
      ST_RESPOND
   } state_type;

   typedef struct packed {
      logic                   known;
      logic [ROM_BITS_W-1:0]  bits;
      logic [MORSE_LEN_W-1:0] len;
   } morse_sym_type;

   // dot/dash pattern of a character, msb first
   function automatic morse_sym_type morse_lookup(input logic [CHAR_W-1:0] ch);
      morse_sym_type s;
      s.known = 1'b1;
      s.bits  = '0;
      s.len   = '0;
      case (ch)
         8'h41: begin s.bits = 32'hB8000000; s.len = 5'd8;  end // A
         8'h42: begin s.bits = 32'hEA800000; s.len = 5'd12; end
         8'h43: begin s.bits = 32'hEBA00000; s.len = 5'd14; end
         8'h44: begin s.bits = 32'hEA000000; s.len = 5'd10; end
         8'h45: begin s.bits = 32'h80000000; s.len = 5'd4;  end
         8'h46: begin s.bits = 32'hAE800000; s.len = 5'd12; end
         8'h47: begin s.bits = 32'hEE800000; s.len = 5'd12; end
         8'h48: begin s.bits = 32'hAA000000; s.len = 5'd10; end
         8'h49: begin s.bits = 32'hA0000000; s.len = 5'd6;  end
         8'h4A: begin s.bits = 32'hBBB80000; s.len = 5'd16; end
         8'h4B: begin s.bits = 32'hEB800000; s.len = 5'd12; end
         8'h4C: begin s.bits = 32'hBA800000; s.len = 5'd12; end
         8'h4D: begin s.bits = 32'hEE000000; s.len = 5'd10; end
         8'h4E: begin s.bits = 32'hE8000000; s.len = 5'd8;  end
         8'h4F: begin s.bits = 32'hEEE00000; s.len = 5'd14; end
         8'h50: begin s.bits = 32'hBBA00000; s.len = 5'd14; end
         8'h51: begin s.bits = 32'hEEB80000; s.len = 5'd16; end
         8'h52: begin s.bits = 32'hBA000000; s.len = 5'd10; end
         8'h53: begin s.bits = 32'hA8000000; s.len = 5'd8;  end
         8'h54: begin s.bits = 32'hE0000000; s.len = 5'd6;  end
         8'h55: begin s.bits = 32'hAE000000; s.len = 5'd10; end
         8'h56: begin s.bits = 32'hAB800000; s.len = 5'd12; end
         8'h57: begin s.bits = 32'hBB800000; s.len = 5'd12; end
         8'h58: begin s.bits = 32'hEAE00000; s.len = 5'd14; end
         8'h59: begin s.bits = 32'hEBB80000; s.len = 5'd16; end
         8'h5A: begin s.bits = 32'hEEA00000; s.len = 5'd14; end // Z
         8'h31: begin s.bits = 32'hBBBB8000; s.len = 5'd20; end // 1
         8'h32: begin s.bits = 32'hAEEE0000; s.len = 5'd18; end
         8'h33: begin s.bits = 32'hABB80000; s.len = 5'd16; end
         8'h34: begin s.bits = 32'hAAE00000; s.len = 5'd14; end
         8'h35: begin s.bits = 32'hAA800000; s.len = 5'd12; end
         8'h36: begin s.bits = 32'hEAA00000; s.len = 5'd14; end
         8'h37: begin s.bits = 32'hEEA80000; s.len = 5'd16; end
         8'h38: begin s.bits = 32'hEEEA0000; s.len = 5'd18; end
         8'h39: begin s.bits = 32'hEEEE8000; s.len = 5'd20; end
         8'h30: begin s.bits = 32'hEEEEE000; s.len = 5'd22; end // 0
         8'h2F: begin s.bits = 32'hEAE80000; s.len = 5'd16; end // slash
         8'h3F: begin s.bits = 32'hAEEA0000; s.len = 5'd18; end // question mark
         8'h2C: begin s.bits = 32'hEEAEE000; s.len = 5'd22; end // comma
         8'h2D: begin s.bits = 32'hEAAE0000; s.len = 5'd18; end // hyphen
         8'h3D: begin s.bits = 32'hEAB80000; s.len = 5'd16; end // equals
         8'h2E: begin s.bits = 32'hBAEB8000; s.len = 5'd20; end // period
         8'h20: begin s.bits = 32'h00000000; s.len = 5'd4;  end // word gap
         default: s.known = 1'b0;
      endcase
      return s;
   endfunction

endpackage

>>> rtl/mktg_ram.sv
// ----------------------------------------------------------------------------
// mktg_ram - generic simple dual port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module mktg_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/morse_keyer_tone_generator.sv
// ----------------------------------------------------------------------------
// morse_keyer_tone_generator - morse keyer with square tone output
// sequence: clear, start, stop, unused codes, idle ticks and skipped appends
//   pass decode and strobe in respond; a tick during playback passes the
//   tick state too, an append the shift state for its bits (at most 22)
// throughput: busy falls the cycle after the strobe, so a request is taken only
//   after the last result; appends are set by the one-bit-per-cycle store write
// reset: synchronous, active high; the pattern store is not swept, a fill mark
//   makes never written bits read as zero; the receiver cannot stall results
// ----------------------------------------------------------------------------
module morse_keyer_tone_generator #(
   parameter int PATTERN_BITS = mktg_pkg::PATTERN_BITS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   start,
   output logic                                   busy,
   input  logic [mktg_pkg::CMD_W-1:0]             req_cmd,
   input  logic [mktg_pkg::CHAR_W-1:0]            req_char_code,
   input  logic                                   req_use_low_level,
   // result channel
   output logic                                   rsp_valid,
   output logic signed [mktg_pkg::SAMPLE_W-1:0]   rsp_sample,
   output logic                                   rsp_wanted,
   output logic                                   rsp_running,
   output logic                                   rsp_load_error,
   // configuration
   input  logic                                   csr_we,
   input  logic [mktg_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [mktg_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   import mktg_pkg::*;

   // pattern index width, and fill mark width (can hold PATTERN_BITS itself)
   localparam int LEN_W = $clog2(PATTERN_BITS);
   localparam int HWM_W = LEN_W + 1;
   localparam logic [LEN_W-1:0] LAST_IDX = LEN_W'(PATTERN_BITS - 1);

   // control state
   state_type state_ff, state_in;

   // latched request
   logic [CMD_W-1:0]  cmd_ff;
   logic [CHAR_W-1:0] char_ff;
   logic              use_low_ff;

   // configuration registers
   logic [DOT_W-1:0]   dot_samples_ff;
   logic [TONE_W-1:0]  tone_period_ff;
   logic [LEVEL_W-1:0] high_level_ff;
   logic [LEVEL_W-1:0] low_level_ff;

   // pattern and playback state
   logic [LEN_W-1:0]  length_ff,   length_in;
   logic [HWM_W-1:0]  fill_ff,     fill_in;      // bits [0, fill) have been written
   logic [LEN_W-1:0]  bit_pos_ff,  bit_pos_in;
   logic [DOT_W-1:0]  dot_cnt_ff,  dot_cnt_in;
   logic [TONE_W-1:0] phase_ff,    phase_in;
   logic              active_ff,   active_in;
   logic              overflow_ff, overflow_in;

   // serial pattern writer: shift register drains msb first into the store
   logic [MORSE_W-1:0]     shift_ff, shift_in;
   logic [MORSE_LEN_W-1:0] count_ff, count_in;

   logic signed [SAMPLE_W-1:0] sample_ff, sample_in;

   // datapath helpers
   morse_sym_type            sym;
   logic                     append_go;
   logic                     last_shift;
   logic                     store_bit;
   logic                     ram_q;
   logic                     tone_bit;
   logic                     running;
   logic                     tone_pos;
   logic signed [SAMPLE_W-1:0] level_ext;
   logic [TONE_W:0]          phase_inc;
   logic [DOT_W:0]           dot_inc;
   logic [LEN_W:0]           pos_inc;
   logic [HWM_W-1:0]         len_inc;

   // ------------------------------------------------------------------------
   // pattern store: one bit per dot element
   // ------------------------------------------------------------------------
   mktg_ram #(
      .WIDTH (1),
      .DEPTH (PATTERN_BITS)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_bit),
      .wr_addr (length_ff),
      .wr_data (shift_ff[MORSE_W-1]),
      .rd_addr (bit_pos_ff),
      .rd_data (ram_q)
   );

   // write one pattern bit per cycle while draining the shift register
   assign store_bit = (state_ff == ST_SHIFT);

   assign sym       = morse_lookup(char_ff);
   assign append_go = (cmd_ff == CMD_APPEND) && sym.known && !overflow_ff;
   // last bit of the character, or the bit that lands on the last store slot
   assign last_shift = (count_ff == MORSE_LEN_W'(1)) || (length_ff == LAST_IDX);

   assign running = (bit_pos_ff != '0) || (dot_cnt_ff != '0) || (phase_ff != '0);

   // ------------------------------------------------------------------------
   // next state
   // ------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (append_go) begin
               state_in = ST_SHIFT;
            end else if ((cmd_ff == CMD_TICK) && active_ff) begin
               // store read issued this cycle, data next cycle
               state_in = ST_TICK;
            end else begin
               state_in = ST_RESPOND;
            end
         end
         ST_SHIFT: begin
            if (last_shift) begin
               state_in = ST_RESPOND;
            end
         end
         ST_TICK:    state_in = ST_RESPOND;
         ST_RESPOND: state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // ------------------------------------------------------------------------
   // handshake outputs
   // ------------------------------------------------------------------------
   always_comb begin
      busy      = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE:    busy = 1'b0;
         ST_RESPOND: rsp_valid = 1'b1;
         default:    busy = 1'b1;
      endcase
   end

   assign rsp_sample     = sample_ff;
   assign rsp_wanted     = active_ff;
   assign rsp_running    = running;
   assign rsp_load_error = overflow_ff;

   // ------------------------------------------------------------------------
   // datapath next values
   // ------------------------------------------------------------------------
   // tone sign: positive in the first half of the tone period
   assign tone_pos  = phase_ff < (tone_period_ff >> 1);
   assign level_ext = use_low_ff ? $signed({1'b0, low_level_ff})
                                 : $signed({1'b0, high_level_ff});
   // bits at or above the fill mark were never written and read as zero
   assign tone_bit  = ram_q && ({1'b0, bit_pos_ff} < fill_ff);

   assign phase_inc = {1'b0, phase_ff} + (TONE_W+1)'(1);
   assign dot_inc   = {1'b0, dot_cnt_ff} + (DOT_W+1)'(1);
   assign pos_inc   = {1'b0, bit_pos_ff} + (LEN_W+1)'(1);
   assign len_inc   = {1'b0, length_ff} + HWM_W'(1);

   always_comb begin
      length_in   = length_ff;
      fill_in     = fill_ff;
      bit_pos_in  = bit_pos_ff;
      dot_cnt_in  = dot_cnt_ff;
      phase_in    = phase_ff;
      active_in   = active_ff;
      overflow_in = overflow_ff;
      shift_in    = shift_ff;
      count_in    = count_ff;
      sample_in   = sample_ff;

      case (state_ff)
         ST_DECODE: begin
            sample_in = '0;
            case (cmd_ff)
               CMD_CLEAR: begin
                  // store bits stay, a playback in progress ends at its next step
                  length_in   = '0;
                  overflow_in = 1'b0;
               end
               CMD_APPEND: begin
                  if (append_go) begin
                     shift_in = sym.bits[ROM_BITS_W-1 -: MORSE_W];
                     count_in = sym.len;
                  end
               end
               CMD_START: begin
                  if (!running) begin
                     active_in  = 1'b1;
                     bit_pos_in = '0;
                     dot_cnt_in = '0;
                     phase_in   = '0;
                  end
               end
               CMD_STOP: begin
                  active_in  = 1'b0;
                  bit_pos_in = '0;
                  dot_cnt_in = '0;
                  phase_in   = '0;
               end
               default: ;
            endcase
         end

         ST_SHIFT: begin
            shift_in = shift_ff << 1;
            count_in = count_ff - MORSE_LEN_W'(1);
            if (len_inc > fill_ff) begin
               fill_in = len_inc;
            end
            if (length_ff == LAST_IDX) begin
               // bit on the last slot is kept, then the pattern is dropped
               length_in   = '0;
               overflow_in = 1'b1;
            end else begin
               length_in = length_in + LEN_W'(1);
            end
         end

         ST_TICK: begin
            if (tone_bit) begin
               sample_in = tone_pos ? level_ext : -level_ext;
            end
            if (phase_inc >= {1'b0, tone_period_ff}) begin
               phase_in = '0;
            end else begin
               phase_in = phase_inc[TONE_W-1:0];
            end
            if (dot_inc >= {1'b0, dot_samples_ff}) begin
               dot_cnt_in = '0;
               if (pos_inc >= {1'b0, length_ff}) begin
                  // past the last bit: playback ends
                  active_in  = 1'b0;
                  bit_pos_in = '0;
                  phase_in   = '0;
               end else begin
                  bit_pos_in = pos_inc[LEN_W-1:0];
               end
            end else begin
               dot_cnt_in = dot_inc[DOT_W-1:0];
            end
         end

         default: ;
      endcase
   end

   // ------------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         length_ff   <= '0;
         fill_ff     <= '0;
         bit_pos_ff  <= '0;
         dot_cnt_ff  <= '0;
         phase_ff    <= '0;
         active_ff   <= 1'b0;
         overflow_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         length_ff   <= length_in;
         fill_ff     <= fill_in;
         bit_pos_ff  <= bit_pos_in;
         dot_cnt_ff  <= dot_cnt_in;
         phase_ff    <= phase_in;
         active_ff   <= active_in;
         overflow_ff <= overflow_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      shift_ff  <= shift_in;
      count_ff  <= count_in;
      sample_ff <= sample_in;
      if (start && !busy) begin
         cmd_ff     <= req_cmd;
         char_ff    <= req_char_code;
         use_low_ff <= req_use_low_level;
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         dot_samples_ff <= DOT_SAMPLES_RST;
         tone_period_ff <= TONE_PERIOD_RST;
         high_level_ff  <= LEVEL_RST;
         low_level_ff   <= LEVEL_RST;
      end else if (csr_we) begin
         case (csr_index)
            REG_DOT_SAMPLES: dot_samples_ff <= csr_wdata[DOT_W-1:0];
            REG_TONE_PERIOD: tone_period_ff <= csr_wdata[TONE_W-1:0];
            REG_HIGH_LEVEL:  high_level_ff  <= csr_wdata[LEVEL_W-1:0];
            REG_LOW_LEVEL:   low_level_ff   <= csr_wdata[LEVEL_W-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------
   // a result strobe lasts one cycle and returns the block to idle
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid && !busy)
      else $error("result strobe longer than one cycle");

   // a taken request always produces busy on the next cycle
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request taken but block not busy");

   // the fill mark always covers the current pattern
   a_fill_covers: assert property (@(posedge clock) disable iff (reset)
      fill_ff >= {1'b0, length_ff})
      else $error("pattern length beyond fill mark");

   // after an overflow the pattern stays empty until a clear
   a_overflow_empty: assert property (@(posedge clock) disable iff (reset)
      overflow_ff |-> (length_ff == '0))
      else $error("pattern grew after overflow");

   // playback counters only move while playback is armed
   a_idle_counters: assert property (@(posedge clock) disable iff (reset)
      !active_ff |-> !running)
      else $error("position counters nonzero while inactive");

endmodule
